// ===== hdl/rsc_pkg.sv =====
// ----------------------------------------------------------------------------
// RSA/CRC shared package
// Widths, command and register codes, reset values and state types used by
// the toy RSA sign/verify engine and its bit-serial units.
// ----------------------------------------------------------------------------
package rsc_pkg;

    // Datapath width of the modular arithmetic.
    localparam int MOD_WIDTH = 16;
    // Counter width for one bit-serial modular multiply.
    localparam int MM_CNT_W  = $clog2(MOD_WIDTH);
    // Exponent and key register widths.
    localparam int EXP_W     = 16;
    localparam int REG_W     = 16;
    localparam int CFG_ADDR_W = 2;

    typedef logic [MOD_WIDTH-1:0]  t_mod;
    typedef logic [EXP_W-1:0]      t_exp;
    typedef logic [REG_W-1:0]      t_reg;
    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;
    typedef logic [1:0]            t_cmd;

    // Commands.
    localparam t_cmd CMD_SIGN      = 2'd0;
    localparam t_cmd CMD_VERIFY    = 2'd1;
    localparam t_cmd CMD_CRC_SIGN  = 2'd2;
    localparam t_cmd CMD_CRC_CHECK = 2'd3;

    // Configuration register indexes.
    localparam t_cfg_addr REG_MODULUS     = 2'd0;
    localparam t_cfg_addr REG_PUBLIC_EXP  = 2'd1;
    localparam t_cfg_addr REG_PRIVATE_EXP = 2'd2;

    // Reset values of the key registers.
    localparam t_reg RST_MODULUS     = 16'd3233;
    localparam t_reg RST_PUBLIC_EXP  = 16'd17;
    localparam t_reg RST_PRIVATE_EXP = 16'd2753;

    // Reflected CRC-16/ARC polynomial.
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Exponentiation sequencer states.
    typedef enum logic [2:0] {
        EX_IDLE,
        EX_RED,
        EX_MUL,
        EX_SQR,
        EX_FIN
    } t_ex_state;

    // Top-level command sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRC,
        ST_EXP_LO,
        ST_EXP_HI,
        ST_LOAD
    } t_top_state;

endpackage

// ===== hdl/rsc_ifs.sv =====
// ----------------------------------------------------------------------------
// RSA/CRC channel interfaces
// Valid/ready channels for command items, result items and key register
// writes.
// ----------------------------------------------------------------------------

// Command item channel.
interface rsc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  byte_in;
    logic [31:0] sig_value;
    logic        last_byte;

    modport source (output valid, output command, output byte_in, output sig_value,
                    output last_byte, input ready);
    modport sink   (input valid, input command, input byte_in, input sig_value,
                    input last_byte, output ready);
endinterface

// Result item channel.
interface rsc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_word;
    logic [7:0]  msg_out;
    logic        match;
    logic [15:0] crc_value;

    modport source (output valid, output result_word, output msg_out, output match,
                    output crc_value, input ready);
    modport sink   (input valid, input result_word, input msg_out, input match,
                    input crc_value, output ready);
endinterface

// Key register write channel.
interface rsc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rsc_pkg::CFG_ADDR_W-1:0]  addr;
    logic [rsc_pkg::REG_W-1:0]       data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== hdl/rsc_modmul.sv =====
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes a * b mod n by interleaved shift-and-add, one bit of b per cycle,
// most significant bit first. Operand a and the running sum stay below n.
// ----------------------------------------------------------------------------
module rsc_modmul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  rsc_pkg::t_mod i_a,
    input  rsc_pkg::t_mod i_b,
    input  rsc_pkg::t_mod i_n,
    output logic          o_done,
    output rsc_pkg::t_mod o_prod
);

    localparam int MW = rsc_pkg::MOD_WIDTH;

    logic                          r_busy;
    logic                          r_done;
    logic [rsc_pkg::MM_CNT_W-1:0]  r_cnt;
    rsc_pkg::t_mod                 r_acc;
    rsc_pkg::t_mod                 r_a;
    rsc_pkg::t_mod                 r_b;
    rsc_pkg::t_mod                 r_n;

    logic [MW:0]    w_dbl;
    logic [MW:0]    w_dbl_sub;
    rsc_pkg::t_mod  w_red;
    logic [MW:0]    w_sum;
    logic [MW:0]    w_sum_sub;
    rsc_pkg::t_mod  n_acc;

    // One step: double the sum, reduce, add a if the current bit is set, reduce.
    always_comb begin
        w_dbl     = {r_acc, 1'b0};
        w_dbl_sub = w_dbl - {1'b0, r_n};
        w_red     = (w_dbl >= {1'b0, r_n}) ? w_dbl_sub[MW-1:0] : w_dbl[MW-1:0];
        w_sum     = {1'b0, w_red} + (r_b[MW-1] ? {1'b0, r_a} : '0);
        w_sum_sub = w_sum - {1'b0, r_n};
        n_acc     = (w_sum >= {1'b0, r_n}) ? w_sum_sub[MW-1:0] : w_sum[MW-1:0];
    end

    // Control: busy for one cycle per multiplier bit, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= rsc_pkg::MM_CNT_W'(MW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: operand load and the serial shift of b.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_n   <= i_n;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[MW-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== hdl/rsc_modexp.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation sequencer
// Right-to-left square and multiply on one shared bit-serial multiplier.
// The base is first reduced mod n by multiplying it with one.
// ----------------------------------------------------------------------------
module rsc_modexp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  rsc_pkg::t_mod i_base,
    input  rsc_pkg::t_exp i_exp,
    input  rsc_pkg::t_mod i_n,
    output logic          o_done,
    output rsc_pkg::t_mod o_result
);

    rsc_pkg::t_ex_state r_state;
    rsc_pkg::t_ex_state n_state;
    logic               r_issued;
    rsc_pkg::t_mod      r_acc;
    rsc_pkg::t_mod      r_b;
    rsc_pkg::t_mod      r_base;
    rsc_pkg::t_mod      r_n;
    rsc_pkg::t_exp      r_x;

    logic               w_small_n;
    logic               w_upper_zero;
    logic               mm_start;
    rsc_pkg::t_mod      mm_a;
    rsc_pkg::t_mod      mm_b;
    logic               mm_done;
    rsc_pkg::t_mod      mm_prod;

    rsc_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_n     (r_n),
        .o_done  (mm_done),
        .o_prod  (mm_prod)
    );

    assign w_small_n    = (i_n < rsc_pkg::MOD_WIDTH'(2));
    assign w_upper_zero = ((r_x >> 1) == '0);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rsc_pkg::EX_IDLE: begin
                if (i_start) begin
                    n_state = w_small_n ? rsc_pkg::EX_FIN : rsc_pkg::EX_RED;
                end
            end
            rsc_pkg::EX_RED: begin
                if (mm_done) begin
                    if (r_x == '0) begin
                        n_state = rsc_pkg::EX_FIN;
                    end else if (r_x[0]) begin
                        n_state = rsc_pkg::EX_MUL;
                    end else begin
                        n_state = rsc_pkg::EX_SQR;
                    end
                end
            end
            rsc_pkg::EX_MUL: begin
                if (mm_done) begin
                    n_state = w_upper_zero ? rsc_pkg::EX_FIN : rsc_pkg::EX_SQR;
                end
            end
            rsc_pkg::EX_SQR: begin
                if (mm_done) begin
                    n_state = r_x[1] ? rsc_pkg::EX_MUL : rsc_pkg::EX_SQR;
                end
            end
            rsc_pkg::EX_FIN: begin
                n_state = rsc_pkg::EX_IDLE;
            end
            default: begin
                n_state = rsc_pkg::EX_IDLE;
            end
        endcase
    end

    // Outputs: multiplier start and operand selection.
    always_comb begin
        mm_start = 1'b0;
        mm_a     = r_b;
        mm_b     = r_b;
        o_done   = 1'b0;
        case (r_state)
            rsc_pkg::EX_RED: begin
                mm_start = !r_issued;
                mm_a     = rsc_pkg::MOD_WIDTH'(1);
                mm_b     = r_base;
            end
            rsc_pkg::EX_MUL: begin
                mm_start = !r_issued;
                mm_a     = r_b;
                mm_b     = r_acc;
            end
            rsc_pkg::EX_SQR: begin
                mm_start = !r_issued;
            end
            rsc_pkg::EX_FIN: begin
                o_done = 1'b1;
            end
            default: begin
                mm_start = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rsc_pkg::EX_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mm_start) begin
                r_issued <= 1'b1;
            end else if (mm_done) begin
                r_issued <= 1'b0;
            end
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            rsc_pkg::EX_IDLE: begin
                if (i_start) begin
                    r_n    <= i_n;
                    r_base <= i_base;
                    r_x    <= i_exp;
                    r_acc  <= w_small_n ? '0 : rsc_pkg::MOD_WIDTH'(1);
                end
            end
            rsc_pkg::EX_RED: begin
                if (mm_done) begin
                    r_b <= mm_prod;
                end
            end
            rsc_pkg::EX_MUL: begin
                if (mm_done) begin
                    r_acc <= mm_prod;
                end
            end
            rsc_pkg::EX_SQR: begin
                if (mm_done) begin
                    r_b <= mm_prod;
                    r_x <= r_x >> 1;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_result = r_acc;

endmodule

// ===== hdl/rsc_crc.sv =====
// ----------------------------------------------------------------------------
// Bit-serial CRC-16/ARC
// Holds the running CRC and folds in one data byte, one bit per cycle.
// ----------------------------------------------------------------------------
module rsc_crc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [7:0]  i_byte,
    input  logic        i_clear,
    output logic        o_done,
    output logic [15:0] o_crc
);

    logic        r_busy;
    logic        r_done;
    logic [2:0]  r_cnt;
    logic [15:0] r_crc;
    logic [15:0] n_crc;

    // One reflected shift step.
    assign n_crc = r_crc[0] ? ((r_crc >> 1) ^ rsc_pkg::CRC_POLY) : (r_crc >> 1);

    // The running CRC resets to zero and clears on i_clear, which the top raises after a finished run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_crc  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_clear) begin
                r_crc <= '0;
            end else if (i_start) begin
                r_crc  <= r_crc ^ {8'h00, i_byte};
                r_busy <= 1'b1;
                r_cnt  <= 3'd7;
            end else if (r_busy) begin
                r_crc <= n_crc;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_crc  = r_crc;

endmodule

// ===== hdl/toy_rsa_sign_verify_crc.sv =====
// ----------------------------------------------------------------------------
// Toy RSA sign/verify engine with CRC-16 front end
// Signs and verifies bytes with 16-bit keys and signs or checks the CRC of a
// byte run, using one bit-serial modular exponentiation unit.
//
//   Channel | Dir | Payload                                     | Handshake
//   i_in    | in  | command, byte_in, sig_value, last_byte      | valid/ready
//   o_out   | out | result_word, msg_out, match, crc_value      | valid/ready
//   i_cfg   | in  | addr (0 modulus, 1 public, 2 private), data | valid/ready
//
// A modular multiply runs on the bit-serial multiplier; one exponentiation
// does one reduction of the base, then s squarings and m multiplies set by
// the exponent bits, and no multiply at all when the modulus is below 2.
// Sign and verify use one exponentiation; a CRC byte is folded in bit by
// bit, and the last byte of a run adds two exponentiations.
// Reset is synchronous and active low; it restores the key reset values and
// clears the CRC. Input transfers are taken while the sequencer is idle, even
// when a finished result is still held in the output register.
// ----------------------------------------------------------------------------
module toy_rsa_sign_verify_crc (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rsc_in_if.sink     i_in,
    rsc_out_if.source  o_out,
    rsc_cfg_if.sink    i_cfg
);

    // Key registers.
    rsc_pkg::t_reg       r_modulus;
    rsc_pkg::t_reg       r_public_exp;
    rsc_pkg::t_reg       r_private_exp;

    // Sequencer.
    rsc_pkg::t_top_state r_state;
    rsc_pkg::t_top_state n_state;
    logic                r_issued;

    // Latched command item and partial results.
    rsc_pkg::t_cmd       r_cmd;
    logic [7:0]          r_byte;
    logic [31:0]         r_sig;
    logic                r_last;
    logic [15:0]         r_crcv;
    logic [15:0]         r_res_lo;
    logic [15:0]         r_res_hi;

    // Output register.
    logic                r_out_valid;
    logic [31:0]         r_out_word;
    logic [7:0]          r_out_msg;
    logic                r_out_match;
    logic [15:0]         r_out_crc;

    logic                w_in_xfer;
    logic                w_out_free;
    logic                w_in_crc;
    logic                w_cmd_crc;
    logic                w_cmd_priv;
    logic                w_unit_done;
    logic                crc_start;
    logic                crc_clear;
    logic                crc_done;
    logic [15:0]         crc_value;
    logic                ex_start;
    logic [15:0]         ex_base;
    rsc_pkg::t_exp       ex_exp;
    logic                ex_done;
    rsc_pkg::t_mod       ex_result;
    logic [15:0]         w_ex_res16;
    logic [31:0]         w_word;
    logic [7:0]          w_msg;
    logic                w_match;
    logic [15:0]         w_crc_out;

    rsc_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (crc_start),
        .i_byte  (r_byte),
        .i_clear (crc_clear),
        .o_done  (crc_done),
        .o_crc   (crc_value)
    );

    rsc_modexp u_modexp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ex_start),
        .i_base   (rsc_pkg::MOD_WIDTH'(ex_base)),
        .i_exp    (ex_exp),
        .i_n      (rsc_pkg::MOD_WIDTH'(r_modulus)),
        .o_done   (ex_done),
        .o_result (ex_result)
    );

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == rsc_pkg::ST_IDLE);
    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_in_crc    = (i_in.command == rsc_pkg::CMD_CRC_SIGN) ||
                         (i_in.command == rsc_pkg::CMD_CRC_CHECK);
    assign w_cmd_crc   = (r_cmd == rsc_pkg::CMD_CRC_SIGN) ||
                         (r_cmd == rsc_pkg::CMD_CRC_CHECK);
    assign w_cmd_priv  = (r_cmd == rsc_pkg::CMD_SIGN) ||
                         (r_cmd == rsc_pkg::CMD_CRC_SIGN);
    assign w_unit_done = (r_state == rsc_pkg::ST_CRC) ? crc_done : ex_done;
    assign w_ex_res16  = 16'(ex_result);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rsc_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = w_in_crc ? rsc_pkg::ST_CRC : rsc_pkg::ST_EXP_LO;
                end
            end
            rsc_pkg::ST_CRC: begin
                if (crc_done) begin
                    n_state = r_last ? rsc_pkg::ST_EXP_LO : rsc_pkg::ST_IDLE;
                end
            end
            rsc_pkg::ST_EXP_LO: begin
                if (ex_done) begin
                    n_state = w_cmd_crc ? rsc_pkg::ST_EXP_HI : rsc_pkg::ST_LOAD;
                end
            end
            rsc_pkg::ST_EXP_HI: begin
                if (ex_done) begin
                    n_state = rsc_pkg::ST_LOAD;
                end
            end
            rsc_pkg::ST_LOAD: begin
                if (w_out_free) begin
                    n_state = rsc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rsc_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: unit starts and exponentiation operands.
    always_comb begin
        crc_start = 1'b0;
        crc_clear = 1'b0;
        ex_start  = 1'b0;
        ex_base   = {8'h00, r_byte};
        ex_exp    = w_cmd_priv ? rsc_pkg::EXP_W'(r_private_exp)
                               : rsc_pkg::EXP_W'(r_public_exp);
        case (r_state)
            rsc_pkg::ST_CRC: begin
                crc_start = !r_issued;
                crc_clear = crc_done && r_last;
            end
            rsc_pkg::ST_EXP_LO: begin
                ex_start = !r_issued;
                case (r_cmd)
                    rsc_pkg::CMD_SIGN:     ex_base = {8'h00, r_byte};
                    rsc_pkg::CMD_CRC_SIGN: ex_base = {8'h00, r_crcv[7:0]};
                    default:               ex_base = r_sig[15:0];
                endcase
            end
            rsc_pkg::ST_EXP_HI: begin
                ex_start = !r_issued;
                ex_base  = (r_cmd == rsc_pkg::CMD_CRC_SIGN) ? {8'h00, r_crcv[15:8]}
                                                            : r_sig[31:16];
            end
            default: begin
                crc_start = 1'b0;
            end
        endcase
    end

    // Result fields assembled from the partial results.
    always_comb begin
        w_word    = '0;
        w_msg     = '0;
        w_match   = 1'b0;
        w_crc_out = '0;
        case (r_cmd)
            rsc_pkg::CMD_SIGN: begin
                w_word = {16'h0000, r_res_lo};
            end
            rsc_pkg::CMD_VERIFY: begin
                w_word  = {16'h0000, r_res_lo};
                w_msg   = r_res_lo[7:0];
                w_match = (r_res_lo == {8'h00, r_byte});
            end
            rsc_pkg::CMD_CRC_SIGN: begin
                w_word    = {r_res_hi, r_res_lo};
                w_crc_out = r_crcv;
            end
            rsc_pkg::CMD_CRC_CHECK: begin
                w_match   = (r_res_lo == {8'h00, r_crcv[7:0]}) &&
                            (r_res_hi == {8'h00, r_crcv[15:8]});
                w_crc_out = r_crcv;
            end
            default: begin
                w_word = '0;
            end
        endcase
    end

    // Control registers: state, unit handshake, key registers, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= rsc_pkg::ST_IDLE;
            r_issued      <= 1'b0;
            r_out_valid   <= 1'b0;
            r_modulus     <= rsc_pkg::RST_MODULUS;
            r_public_exp  <= rsc_pkg::RST_PUBLIC_EXP;
            r_private_exp <= rsc_pkg::RST_PRIVATE_EXP;
        end else begin
            r_state <= n_state;
            if (crc_start || ex_start) begin
                r_issued <= 1'b1;
            end else if (w_unit_done) begin
                r_issued <= 1'b0;
            end
            if ((r_state == rsc_pkg::ST_LOAD) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.addr)
                    rsc_pkg::REG_MODULUS:     r_modulus     <= i_cfg.data;
                    rsc_pkg::REG_PUBLIC_EXP:  r_public_exp  <= i_cfg.data;
                    rsc_pkg::REG_PRIVATE_EXP: r_private_exp <= i_cfg.data;
                    default:                  r_modulus     <= r_modulus;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cmd  <= i_in.command;
            r_byte <= i_in.byte_in;
            r_sig  <= i_in.sig_value;
            r_last <= i_in.last_byte;
        end
        if ((r_state == rsc_pkg::ST_CRC) && crc_done) begin
            r_crcv <= crc_value;
        end
        if ((r_state == rsc_pkg::ST_EXP_LO) && ex_done) begin
            r_res_lo <= w_ex_res16;
        end
        if ((r_state == rsc_pkg::ST_EXP_HI) && ex_done) begin
            r_res_hi <= w_ex_res16;
        end
        if ((r_state == rsc_pkg::ST_LOAD) && w_out_free) begin
            r_out_word  <= w_word;
            r_out_msg   <= w_msg;
            r_out_match <= w_match;
            r_out_crc   <= w_crc_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_word = r_out_word;
    assign o_out.msg_out     = r_out_msg;
    assign o_out.match       = r_out_match;
    assign o_out.crc_value   = r_out_crc;

endmodule

// ===== tb/sv/toy_rsa_sign_verify_crc_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Toy RSA sign/verify engine with CRC-16 front end: testbench
// Drives sign, verify and CRC byte runs through the command channel under
// several key settings. A scoreboard predicts every result word, recovered
// byte, match flag and CRC value, and checks them in order on the result
// channel. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module toy_rsa_sign_verify_crc_tb;

    // One command transfer.
    typedef struct {
        rsc_pkg::t_cmd cmd;
        logic [7:0]    data_byte;
        logic [31:0]   sig;
        logic          last;
    } t_cmd_item;

    // One result transfer.
    typedef struct {
        logic [31:0] word;
        logic [7:0]  msg;
        logic        match;
        logic [15:0] crc;
    } t_rsa_result;

    // One set of key register values.
    typedef struct {
        rsc_pkg::t_reg modulus;
        rsc_pkg::t_reg pub;
        rsc_pkg::t_reg priv;
    } t_key_set;

    // Tracks keys and the running CRC, predicts results and checks them in order.
    class rsa_crc_scoreboard;
        rsc_pkg::t_reg modulus;
        rsc_pkg::t_reg public_exp;
        rsc_pkg::t_reg private_exp;
        logic [15:0]   crc_state;
        t_rsa_result   expected_q[$];
        int unsigned   errors;
        int unsigned   checked;

        function new();
            modulus     = rsc_pkg::RST_MODULUS;
            public_exp  = rsc_pkg::RST_PUBLIC_EXP;
            private_exp = rsc_pkg::RST_PRIVATE_EXP;
            crc_state   = '0;
            errors      = 0;
            checked     = 0;
        endfunction

        // Square-and-multiply with wide intermediates; moduli below 2 give 0.
        function logic [63:0] modexp(logic [63:0] base, logic [15:0] expo, logic [15:0] n);
            logic [63:0] acc;
            logic [63:0] b;
            logic [63:0] nn;
            logic [15:0] x;
            nn = {48'd0, n};
            x  = expo;
            if (nn < 2) return 64'd0;
            acc = 64'd1;
            b   = base % nn;
            while (x != 0) begin
                if (x[0]) acc = (acc * b) % nn;
                b = (b * b) % nn;
                x = x >> 1;
            end
            return acc;
        endfunction

        // One byte of reflected CRC-16/ARC.
        function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            for (int i = 0; i < 8; i++) begin
                r = r[0] ? ((r >> 1) ^ rsc_pkg::CRC_POLY) : (r >> 1);
            end
            return r;
        endfunction

        function void set_key(rsc_pkg::t_cfg_addr addr, rsc_pkg::t_reg value);
            case (addr)
                rsc_pkg::REG_MODULUS:     modulus     = value;
                rsc_pkg::REG_PUBLIC_EXP:  public_exp  = value;
                rsc_pkg::REG_PRIVATE_EXP: private_exp = value;
                default: ;
            endcase
        endfunction

        // Called on every accepted command transfer.
        function void note_command(t_cmd_item it);
            t_rsa_result r;
            logic [63:0] m;
            logic [63:0] lo_v;
            logic [63:0] hi_v;
            logic [15:0] c;
            r = '{32'd0, 8'd0, 1'b0, 16'd0};
            case (it.cmd)
                rsc_pkg::CMD_SIGN: begin
                    m = modexp({56'd0, it.data_byte}, private_exp, modulus);
                    r.word = m[31:0];
                end
                rsc_pkg::CMD_VERIFY: begin
                    m = modexp({48'd0, it.sig[15:0]}, public_exp, modulus);
                    r.word  = m[31:0];
                    r.msg   = m[7:0];
                    r.match = (m == {56'd0, it.data_byte});
                end
                default: begin
                    c = crc16_step(crc_state, it.data_byte);
                    if (!it.last) begin
                        crc_state = c;
                        return;
                    end
                    crc_state = '0;
                    r.crc = c;
                    if (it.cmd == rsc_pkg::CMD_CRC_SIGN) begin
                        lo_v = modexp({56'd0, c[7:0]}, private_exp, modulus);
                        hi_v = modexp({56'd0, c[15:8]}, private_exp, modulus);
                        r.word = {hi_v[15:0], lo_v[15:0]};
                    end else begin
                        lo_v = modexp({48'd0, it.sig[15:0]}, public_exp, modulus);
                        hi_v = modexp({48'd0, it.sig[31:16]}, public_exp, modulus);
                        r.match = (lo_v == {56'd0, c[7:0]}) && (hi_v == {56'd0, c[15:8]});
                    end
                end
            endcase
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        // Called on every accepted result transfer.
        task check_result(t_rsa_result got);
            t_rsa_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("result with none pending, word %h", got.word));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.word !== want.word)
                report($sformatf("result_word %h, predicted %h", got.word, want.word));
            if (got.msg !== want.msg)
                report($sformatf("msg_out %h, predicted %h", got.msg, want.msg));
            if (got.match !== want.match)
                report($sformatf("match %b, predicted %b", got.match, want.match));
            if (got.crc !== want.crc)
                report($sformatf("crc_value %h, predicted %h", got.crc, want.crc));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    rsc_in_if  cmd_if ();
    rsc_out_if res_if ();
    rsc_cfg_if key_if ();

    toy_rsa_sign_verify_crc u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if),
        .i_cfg   (key_if)
    );

    rsa_crc_scoreboard sb = new();
    int unsigned       send_gap_pct;
    int unsigned       recv_stall_pct;
    int unsigned       sent_count;
    t_key_set          plan[9];

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit, well above the slowest legal run.
    initial begin
        #60_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Result receiver: random stalls, changed on the falling edge.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every accepted result transfer goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_result('{res_if.result_word, res_if.msg_out, res_if.match,
                              res_if.crc_value});
    end

    // Signature of one byte under the current keys.
    function automatic logic [15:0] sign_of(logic [7:0] x);
        logic [63:0] s;
        s = sb.modexp({56'd0, x}, sb.private_exp, sb.modulus);
        return s[15:0];
    endfunction

    // Signature pair that validates a run ending with this byte.
    function automatic logic [31:0] crc_sig(logic [7:0] b);
        logic [15:0] c;
        c = sb.crc16_step(sb.crc_state, b);
        return {sign_of(c[15:8]), sign_of(c[7:0])};
    endfunction

    function automatic t_cmd_item make_item(rsc_pkg::t_cmd c, logic [7:0] b, logic [31:0] s,
                                            logic l);
        t_cmd_item it;
        it.cmd       = c;
        it.data_byte = b;
        it.sig       = s;
        it.last      = l;
        return it;
    endfunction

    // A sign or verify command; most verifies carry a genuine signature.
    function automatic t_cmd_item random_single();
        t_cmd_item   it;
        logic [7:0]  b;
        it = make_item(rsc_pkg::CMD_SIGN, 8'($urandom), $urandom, 1'($urandom));
        if ($urandom_range(1) == 1) begin
            it.cmd = rsc_pkg::CMD_VERIFY;
            if ($urandom_range(9) < 6) begin
                b = 8'($urandom);
                it.sig[15:0] = sign_of(b);
                if ($urandom_range(4) != 0) it.data_byte = b;
            end
        end
        return it;
    endfunction

    // Drives one command and returns at the edge where it transfers.
    task send_command(t_cmd_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            cmd_if.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_if.command   = it.cmd;
        cmd_if.byte_in   = it.data_byte;
        cmd_if.sig_value = it.sig;
        cmd_if.last_byte = it.last;
        cmd_if.valid     = 1'b1;
        do @(posedge i_clk); while (!cmd_if.ready);
        sb.note_command(it);
        sent_count++;
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task drain(int unsigned settle);
        @(negedge i_clk);
        cmd_if.valid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task write_key(rsc_pkg::t_cfg_addr addr, rsc_pkg::t_reg value);
        @(negedge i_clk);
        key_if.addr  = addr;
        key_if.data  = value;
        key_if.valid = 1'b1;
        do @(posedge i_clk); while (!key_if.ready);
        sb.set_key(addr, value);
        @(negedge i_clk);
        key_if.valid = 1'b0;
    endtask

    // Random traffic: mostly CRC runs with interleaved commands, plus singles.
    task run_random(int unsigned quota);
        int unsigned   made;
        int unsigned   r;
        int unsigned   len;
        rsc_pkg::t_cmd mode;
        t_cmd_item     it;
        made = 0;
        while (made < quota) begin
            r = $urandom_range(99);
            if (r < 2) begin
                drain(0);
            end else if (r < 50) begin
                len  = $urandom_range(1, 6);
                mode = ($urandom_range(1) == 1) ? rsc_pkg::CMD_CRC_SIGN
                                                : rsc_pkg::CMD_CRC_CHECK;
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(9) == 0) begin
                        send_command(random_single());
                        made++;
                    end
                    it = make_item(mode, 8'($urandom), $urandom, (k == len - 1));
                    // Occasional mode switch or early end breaks the run.
                    if ($urandom_range(9) == 0)
                        it.cmd = (mode == rsc_pkg::CMD_CRC_SIGN) ? rsc_pkg::CMD_CRC_CHECK
                                                                 : rsc_pkg::CMD_CRC_SIGN;
                    if ($urandom_range(19) == 0) it.last = 1'b1;
                    if (it.last && it.cmd == rsc_pkg::CMD_CRC_CHECK &&
                        $urandom_range(9) < 7) begin
                        it.sig = crc_sig(it.data_byte);
                        if ($urandom_range(4) == 0)
                            it.sig[5'($urandom_range(31))] ^= 1'b1;
                    end
                    send_command(it);
                    made++;
                end
            end else begin
                send_command(random_single());
                made++;
            end
        end
    endtask

    // Main sequence.
    initial begin
        i_rst_n          = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.command   = rsc_pkg::CMD_SIGN;
        cmd_if.byte_in   = '0;
        cmd_if.sig_value = '0;
        cmd_if.last_byte = 1'b0;
        key_if.valid     = 1'b0;
        key_if.addr      = rsc_pkg::REG_MODULUS;
        key_if.data      = '0;
        send_gap_pct     = 32;
        recv_stall_pct   = 62;
        sent_count       = 0;

        // Key plans: textbook pairs, extremes, tiny moduli and random keys.
        plan[0] = '{16'd143, 16'd7, 16'd103};
        plan[1] = '{16'd55, 16'd3, 16'd27};
        plan[2] = '{16'd64507, 16'd3, 16'd42667};
        plan[3] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        plan[4] = '{16'd2, 16'd0, 16'd0};
        plan[5] = '{16'd1, rsc_pkg::t_reg'($urandom), rsc_pkg::t_reg'($urandom)};
        plan[6] = '{16'd0, rsc_pkg::t_reg'($urandom), rsc_pkg::t_reg'($urandom)};
        plan[7] = '{rsc_pkg::t_reg'($urandom_range(2, 65535)), rsc_pkg::t_reg'($urandom),
                    rsc_pkg::t_reg'($urandom)};
        plan[8] = '{rsc_pkg::RST_MODULUS, rsc_pkg::RST_PUBLIC_EXP, rsc_pkg::RST_PRIVATE_EXP};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part under the reset keys.
        send_command(make_item(rsc_pkg::CMD_SIGN, 8'h00, $urandom, 1'b0));
        send_command(make_item(rsc_pkg::CMD_SIGN, 8'hFF, $urandom, 1'b1));
        send_command(make_item(rsc_pkg::CMD_VERIFY, 8'h00, 32'hFFFF0000, 1'b0));
        send_command(make_item(rsc_pkg::CMD_VERIFY, 8'hFF, 32'h0000FFFF, 1'b1));
        send_command(make_item(rsc_pkg::CMD_VERIFY, 8'h41, {16'hA5A5, sign_of(8'h41)}, 1'b0));
        send_command(make_item(rsc_pkg::CMD_VERIFY, 8'h42, {16'h5A5A, sign_of(8'h41)}, 1'b0));
        // Two-byte signed run.
        send_command(make_item(rsc_pkg::CMD_CRC_SIGN, 8'h00, $urandom, 1'b0));
        send_command(make_item(rsc_pkg::CMD_CRC_SIGN, 8'hFF, $urandom, 1'b1));
        // Validated run with sign and verify in the middle.
        send_command(make_item(rsc_pkg::CMD_CRC_CHECK, 8'h31, 32'd0, 1'b0));
        send_command(make_item(rsc_pkg::CMD_SIGN, 8'h80, $urandom, 1'b0));
        send_command(make_item(rsc_pkg::CMD_VERIFY, 8'h80, $urandom, 1'b1));
        send_command(make_item(rsc_pkg::CMD_CRC_CHECK, 8'h32, crc_sig(8'h32), 1'b1));
        // Single-byte run with a bad signature.
        send_command(make_item(rsc_pkg::CMD_CRC_CHECK, 8'hAA, 32'hFFFFFFFF, 1'b1));
        // Runs that switch mode before the last byte.
        send_command(make_item(rsc_pkg::CMD_CRC_SIGN, 8'h12, 32'd0, 1'b0));
        send_command(make_item(rsc_pkg::CMD_CRC_CHECK, 8'h34, crc_sig(8'h34), 1'b1));
        send_command(make_item(rsc_pkg::CMD_CRC_CHECK, 8'h56, 32'd0, 1'b0));
        send_command(make_item(rsc_pkg::CMD_CRC_SIGN, 8'h78, 32'd0, 1'b1));

        // Random part, one key setting per phase.
        for (int p = 0; p < 9; p++) begin
            drain(40);
            if (p == 3) begin
                send_gap_pct   = 62;
                recv_stall_pct = 32;
            end else if (p == 6) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            write_key(rsc_pkg::REG_MODULUS, plan[p].modulus);
            write_key(rsc_pkg::REG_PUBLIC_EXP, plan[p].pub);
            write_key(rsc_pkg::REG_PRIVATE_EXP, plan[p].priv);
            run_random((p == 5 || p == 6) ? 30 : 130);
        end

        // Wait for the last results, then watch for anything extra.
        drain(1200);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        $display("Sent %0d commands and checked %0d results over %0d key settings.",
                 sent_count, sb.checked, 10);
        $display("Covered tiny to all-ones keys, mixed CRC runs, and idle and stall mixes.");
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
